/* hdl/pcf_pkg.sv */
`default_nettype none
package pcf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int SQW       = 2 * DW;
  localparam int MU_W      = 17;
  localparam int MU_FRAC   = 16;
  localparam int STEPS     = DW;
  // stages of one contact: operands, radicand, root steps, products, quotient steps, result
  localparam int CONTACT_LAT = 2 * STEPS + 4;
  localparam int ADDR_W    = 3;

  localparam logic [DW-1:0]   HEIGHT_RST = DW'((-(3 * (2 ** FRAC_BITS))) / 4);
  localparam logic [MU_W-1:0] MU_RST     = MU_W'(26214);

  typedef enum logic {
    REG_HEIGHT = 1'b0,
    REG_MU     = 1'b1
  } reg_idx_e;

  // one contact: normal component and the two tangential components
  typedef struct packed {
    logic signed [DW-1:0] vn;
    logic signed [DW-1:0] ta;
    logic signed [DW-1:0] tb;
  } vec_t;

  typedef struct packed {
    logic          hit;
    logic [DW-1:0] lim;
    vec_t          v;
  } sq_side_t;

  typedef struct packed {
    logic hit;
    logic stop;
    vec_t v;
  } dv_side_t;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] c);
    mag = c[DW-1] ? DW'(-c) : DW'(c);
  endfunction

endpackage
`default_nettype wire

/* hdl/pcf_isqrt.sv */
`default_nettype none
module pcf_isqrt import pcf_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [SQW-1:0] rad_i,
  input  wire sq_side_t       side_i,
  output logic                valid_o,
  output logic [DW-1:0]       root_o,
  output sq_side_t            side_o
);

  logic [STEPS-1:0] vld_q;
  logic [SQW-1:0]   x_q    [STEPS];
  logic [SQW-1:0]   r_q    [STEPS];
  sq_side_t         side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [SQW-1:0] x_in, r_in, bit_v, trial, x_d, r_d;
    logic           v_in;
    sq_side_t       s_in;

    if (k == 0) begin : g_first
      assign x_in = rad_i;
      assign r_in = '0;
      assign v_in = valid_i;
      assign s_in = side_i;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign r_in = r_q[k-1];
      assign v_in = vld_q[k-1];
      assign s_in = side_q[k-1];
    end

    assign bit_v = SQW'(1) << (2 * (STEPS - 1 - k));
    assign trial = r_in + bit_v;

    always_comb begin
      if (x_in >= trial) begin
        x_d = x_in - trial;
        r_d = (r_in >> 1) + bit_v;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_d;
        r_q[k]    <= r_d;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign root_o  = r_q[STEPS-1][DW-1:0];
  assign side_o  = side_q[STEPS-1];

endmodule
`default_nettype wire

/* hdl/pcf_div2.sv */
`default_nettype none
module pcf_div2 import pcf_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [SQW-1:0] dvd_a_i,
  input  wire logic [SQW-1:0] dvd_b_i,
  input  wire logic [DW-1:0]  dvs_i,
  input  wire dv_side_t       side_i,
  output logic                valid_o,
  output logic [DW-1:0]       quo_a_o,
  output logic [DW-1:0]       quo_b_o,
  output dv_side_t            side_o
);

  // one restoring step: {quotient bit, next remainder}
  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nb,
                                           input logic [DW-1:0] d);
    logic [DW:0] r2, df;
    r2 = {rem, nb};
    df = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) div_step = {1'b1, df[DW-1:0]};
    else                 div_step = {1'b0, r2[DW-1:0]};
  endfunction

  logic [STEPS-1:0] vld_q;
  logic [DW-1:0]    rema_q [STEPS];
  logic [DW-1:0]    lowa_q [STEPS];
  logic [DW-1:0]    quoa_q [STEPS];
  logic [DW-1:0]    remb_q [STEPS];
  logic [DW-1:0]    lowb_q [STEPS];
  logic [DW-1:0]    quob_q [STEPS];
  logic [DW-1:0]    dvs_q  [STEPS];
  dv_side_t         side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [DW-1:0] ra, la, qa, rb, lb, qb, d;
    logic          v_in;
    dv_side_t      s_in;
    logic [DW:0]   sa, sb;

    if (k == 0) begin : g_first
      assign ra   = dvd_a_i[SQW-1:DW];
      assign la   = dvd_a_i[DW-1:0];
      assign qa   = '0;
      assign rb   = dvd_b_i[SQW-1:DW];
      assign lb   = dvd_b_i[DW-1:0];
      assign qb   = '0;
      assign d    = dvs_i;
      assign v_in = valid_i;
      assign s_in = side_i;
    end else begin : g_next
      assign ra   = rema_q[k-1];
      assign la   = lowa_q[k-1];
      assign qa   = quoa_q[k-1];
      assign rb   = remb_q[k-1];
      assign lb   = lowb_q[k-1];
      assign qb   = quob_q[k-1];
      assign d    = dvs_q[k-1];
      assign v_in = vld_q[k-1];
      assign s_in = side_q[k-1];
    end

    assign sa = div_step(ra, la[DW-1], d);
    assign sb = div_step(rb, lb[DW-1], d);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rema_q[k] <= sa[DW-1:0];
        lowa_q[k] <= la << 1;
        quoa_q[k] <= {qa[DW-2:0], sa[DW]};
        remb_q[k] <= sb[DW-1:0];
        lowb_q[k] <= lb << 1;
        quob_q[k] <= {qb[DW-2:0], sb[DW]};
        dvs_q[k]  <= d;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign quo_a_o = quoa_q[STEPS-1];
  assign quo_b_o = quob_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule
`default_nettype wire

/* hdl/pcf_contact.sv */
`default_nettype none
module pcf_contact import pcf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic            act_i,
  input  wire logic [MU_W-1:0] mu_i,
  input  wire vec_t            vec_i,
  output logic                 valid_o,
  output vec_t                 vec_o
);

  // operands: friction limit and squared tangential magnitudes
  logic [DW-1:0]        n_in, ma_in, mb_in;
  logic [MU_W+DW-1:0]   lim_prod;
  logic [SQW-1:0]       sqa_d, sqb_d;

  logic                 s1_vld_q, s1_hit_q;
  logic [DW-1:0]        s1_lim_q;
  logic [SQW-1:0]       s1_sqa_q, s1_sqb_q;
  vec_t                 s1_vec_q;

  logic                 s2_vld_q;
  logic [SQW-1:0]       s2_rad_q;
  sq_side_t             s2_side_q;

  logic                 sq_vld;
  logic [DW-1:0]        sq_root;
  sq_side_t             sq_side;

  logic [DW-1:0]        s3_ma, s3_mb;
  logic [SQW-1:0]       s3_pa_d, s3_pb_d;
  logic                 s3_vld_q;
  logic [SQW-1:0]       s3_pa_q, s3_pb_q;
  logic [DW-1:0]        s3_dvs_q;
  dv_side_t             s3_side_q;

  logic                 dv_vld;
  logic [DW-1:0]        dv_qa, dv_qb;
  dv_side_t             dv_side;

  logic [DW-1:0]        na, nb;
  vec_t                 res_d;
  logic                 out_vld_q;
  vec_t                 out_vec_q;

  assign n_in     = DW'(-vec_i.vn);
  assign ma_in    = mag(vec_i.ta);
  assign mb_in    = mag(vec_i.tb);
  assign lim_prod = (MU_W+DW)'(mu_i) * (MU_W+DW)'(n_in);
  assign sqa_d    = SQW'(ma_in) * SQW'(ma_in);
  assign sqb_d    = SQW'(mb_in) * SQW'(mb_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q  <= valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= sq_vld;
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_hit_q  <= act_i & vec_i.vn[DW-1];
      s1_lim_q  <= lim_prod[MU_FRAC +: DW];
      s1_sqa_q  <= sqa_d;
      s1_sqb_q  <= sqb_d;
      s1_vec_q  <= vec_i;
      s2_rad_q  <= s1_sqa_q + s1_sqb_q;
      s2_side_q <= '{hit: s1_hit_q, lim: s1_lim_q, v: s1_vec_q};
      s3_pa_q   <= s3_pa_d;
      s3_pb_q   <= s3_pb_d;
      s3_dvs_q  <= sq_root;
      s3_side_q <= '{hit: sq_side.hit, stop: (sq_root <= sq_side.lim), v: sq_side.v};
      out_vec_q <= res_d;
    end
  end

  pcf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (s2_vld_q),
    .rad_i   (s2_rad_q),
    .side_i  (s2_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign s3_ma   = mag(sq_side.v.ta);
  assign s3_mb   = mag(sq_side.v.tb);
  assign s3_pa_d = SQW'(s3_ma) * SQW'(sq_side.lim);
  assign s3_pb_d = SQW'(s3_mb) * SQW'(sq_side.lim);

  pcf_div2 u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (s3_vld_q),
    .dvd_a_i (s3_pa_q),
    .dvd_b_i (s3_pb_q),
    .dvs_i   (s3_dvs_q),
    .side_i  (s3_side_q),
    .valid_o (dv_vld),
    .quo_a_o (dv_qa),
    .quo_b_o (dv_qb),
    .side_o  (dv_side)
  );

  assign na = mag(dv_side.v.ta) - dv_qa;
  assign nb = mag(dv_side.v.tb) - dv_qb;

  always_comb begin
    res_d = dv_side.v;
    if (dv_side.hit) begin
      res_d.vn = '0;
      if (dv_side.stop) begin
        res_d.ta = '0;
        res_d.tb = '0;
      end else begin
        res_d.ta = dv_side.v.ta[DW-1] ? (~na + 1'b1) : na;
        res_d.tb = dv_side.v.tb[DW-1] ? (~nb + 1'b1) : nb;
      end
    end
  end

  assign valid_o = out_vld_q;
  assign vec_o   = out_vec_q;

endmodule
`default_nettype wire

/* hdl/particle_plane_friction_collision.sv */
// channel  | dir | handshake                    | payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | pos_x, pos_z, vel_x, vel_y, vel_z
// m_axis   | out | m_axis_tvalid/m_axis_tready  | new_vel_x, new_vel_y, new_vel_z
// apb      | in  | psel/penable/pready          | plane_height @0x0, friction_coeff @0x4
//
// One word enters per cycle while the output register is empty or taken.
// Each word passes the floor then the wall contact, each a 32-step root
// pipeline followed by a 32-step quotient pipeline.
// All stages advance together whenever the output register is empty or taken.
// Reset clears valid bits and loads plane_height -0.75 and friction_coeff 26214.
`default_nettype none
module particle_plane_friction_collision import pcf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // pos_x, pos_z, vel_x, vel_y, vel_z
  input  wire logic [5*DW-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // new_vel_x, new_vel_y, new_vel_z
  output logic [3*DW-1:0]        m_axis_tdata,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DW-1:0]     pwdata,
  output logic [DW-1:0]          prdata,
  output logic                   pready
);

  logic [DW-1:0]          height_q;
  logic [MU_W-1:0]        mu_q;
  logic                   en;
  logic                   cfg_wr;
  reg_idx_e               cfg_idx;

  logic signed [DW-1:0]   pos_x, pos_z;
  vec_t                   floor_in, floor_out, wall_in, wall_out;
  logic                   floor_act, wall_act, floor_vld, wall_vld;
  logic [CONTACT_LAT-1:0] wact_q;

  logic                   out_vld_q;
  logic [3*DW-1:0]        out_data_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HEIGHT_RST;
      mu_q     <= MU_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HEIGHT: height_q <= pwdata;
        REG_MU:     mu_q     <= pwdata[MU_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HEIGHT: prdata = height_q;
      REG_MU:     prdata = DW'(mu_q);
      default:    prdata = '0;
    endcase
  end

  // advance the whole pipeline unless a finished word is stuck at the output
  assign en            = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = en;

  assign pos_x       = s_axis_tdata[0*DW +: DW];
  assign pos_z       = s_axis_tdata[1*DW +: DW];
  assign floor_in.ta = s_axis_tdata[2*DW +: DW];
  assign floor_in.tb = s_axis_tdata[3*DW +: DW];
  assign floor_in.vn = s_axis_tdata[4*DW +: DW];
  assign floor_act   = pos_z <= $signed(height_q);
  assign wall_act    = pos_x <= $signed(height_q);

  pcf_contact u_floor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .act_i   (floor_act),
    .mu_i    (mu_q),
    .vec_i   (floor_in),
    .valid_o (floor_vld),
    .vec_o   (floor_out)
  );

  // hold the wall test alongside the floor contact
  always_ff @(posedge clk_i) begin
    if (en) begin
      wact_q <= {wact_q[CONTACT_LAT-2:0], wall_act};
    end
  end

  assign wall_in.vn = floor_out.ta;
  assign wall_in.ta = floor_out.tb;
  assign wall_in.tb = floor_out.vn;

  pcf_contact u_wall (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (floor_vld),
    .act_i   (wact_q[CONTACT_LAT-1]),
    .mu_i    (mu_q),
    .vec_i   (wall_in),
    .valid_o (wall_vld),
    .vec_o   (wall_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= wall_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {wall_out.tb, wall_out.ta, wall_out.vn};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

/* hdl/pcf_checker.sv */
`default_nettype none
module pcf_checker import pcf_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            s_axis_tready,
  input wire logic            m_axis_tvalid,
  input wire logic            m_axis_tready,
  input wire logic [3*DW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output room");

endmodule

bind particle_plane_friction_collision pcf_checker u_pcf_checker (.*);
`default_nettype wire

/* tb/tb_particle_plane_friction_collision.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_particle_plane_friction_collision;
  import pcf_pkg::*;

  localparam int NUM_RANDOM = 1950;
  localparam int DRAIN_CYCLES = 160;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] vel_z;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_x;
  } particle_t;

  typedef struct packed {
    logic signed [31:0] vel_z;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
  } velocity_t;

  typedef struct {
    particle_t p;
    logic      known;
    velocity_t v;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [5*DW-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [3*DW-1:0]  m_axis_tdata;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DW-1:0]    pwdata = '0;
  logic [DW-1:0]    prdata;
  logic             pready;

  // shadow copies of the plane height and the friction coefficient
  logic signed [31:0] model_height;
  logic [16:0]        model_mu;

  velocity_t expected_vel_q[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  bit  stim_done = 1'b0;

  particle_plane_friction_collision u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] c);
    return c < 0 ? -c : c;
  endfunction

  function automatic logic signed [63:0] shorten(logic signed [63:0] c,
                                                  logic [63:0] l, logic [63:0] t);
    logic [63:0] m;
    logic [63:0] r;
    m = abs64(c);
    r = m - (m * l) / t;
    return c < 0 ? -$signed(r) : $signed(r);
  endfunction

  function automatic void apply_friction(inout logic signed [63:0] vn,
                                         inout logic signed [63:0] ta,
                                         inout logic signed [63:0] tb);
    logic [63:0] n;
    logic [63:0] l;
    logic [63:0] t;
    if (vn >= 0) return;
    n = -vn;
    l = (64'(model_mu) * n) >> 16;
    t = int_sqrt(abs64(ta) * abs64(ta) + abs64(tb) * abs64(tb));
    vn = 0;
    if (t <= l) begin
      ta = 0;
      tb = 0;
    end else begin
      ta = shorten(ta, l, t);
      tb = shorten(tb, l, t);
    end
  endfunction

  function automatic velocity_t collide(particle_t p);
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [63:0] vz;
    velocity_t r;
    vx = p.vel_x;
    vy = p.vel_y;
    vz = p.vel_z;
    if (p.pos_z <= model_height) apply_friction(vz, vx, vy);
    if (p.pos_x <= model_height) apply_friction(vx, vy, vz);
    r.vel_x = vx[31:0];
    r.vel_y = vy[31:0];
    r.vel_z = vz[31:0];
    return r;
  endfunction

  task automatic apb_write(reg_idx_e idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_HEIGHT) model_height = value;
    else model_mu = value[16:0];
  endtask

  task automatic wait_idle();
    while (expected_vel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // offer one word, queue its expected velocity, and hold until accepted
  task automatic send_particle(particle_t p, logic known, velocity_t v);
    velocity_t pred;
    pred = collide(p);
    if (known && pred !== v)
      $display("table row disagrees with prediction: %h vs %h", v, pred);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_vel_q = {expected_vel_q, known ? v : pred};
  endtask

  task automatic send_with_gap(particle_t p, logic known, velocity_t v, bit gaps);
    int g;
    send_particle(p, known, v);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? model_height : model_height + 1;
      3: return model_height - $urandom_range(0, 65536 * 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 20))
                                     : -32'($urandom_range(0, 1 << 20));
      4: return $signed($urandom) >>> $urandom_range(0, 24);
      default: return $urandom;
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    // mostly in contact so the friction paths get exercised
    if ($urandom_range(0, 3) != 0) begin
      p.pos_x = $urandom_range(0, 2) ? model_height - $urandom_range(0, 1 << 18)
                                     : rand_coord();
      p.pos_z = $urandom_range(0, 2) ? model_height - $urandom_range(0, 1 << 18)
                                     : rand_coord();
    end else begin
      p.pos_x = rand_coord();
      p.pos_z = rand_coord();
    end
    p.vel_x = rand_vel();
    p.vel_y = rand_vel();
    p.vel_z = rand_vel();
    return p;
  endfunction

  function automatic stim_row_t row(logic [31:0] px, logic [31:0] pz, logic [31:0] vx,
                                    logic [31:0] vy, logic [31:0] vz, logic known,
                                    logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
    stim_row_t r;
    r.p = '{vel_z: vz, vel_y: vy, vel_x: vx, pos_z: pz, pos_x: px};
    r.known = known;
    r.v = '{vel_z: ez, vel_y: ey, vel_x: ex};
    return r;
  endfunction

  stim_row_t directed[$];

  function automatic void add_row(stim_row_t r);
    directed = {directed, r};
  endfunction

  initial begin
    logic [31:0] heights[5];
    logic [16:0] mus[5];
    model_height = HEIGHT_RST;
    model_mu = MU_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: above both planes passes through, zero tangent stops dead
    add_row(row(0, 0, 5, 6, -7, 1, 5, 6, -7));
    add_row(row(0, -32'd65536, 0, 0, -32'd65536, 1, 0, 0, 0));
    add_row(row(-32'd65536, 0, -32'd65536, 0, 0, 1, 0, 0, 0));
    add_row(row(32'hffff4000, 32'hffff4000, 3, 4, -32'd100, 1, 0, 0, 0));
    add_row(row(32'hffff4001, 32'hffff4001, 3, 4, -32'd100, 1, 3, 4, -32'd100));
    add_row(row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 0, 0, 0, 0));
    add_row(row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    add_row(row(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    add_row(row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                -32'd1, 0, 0, 0, 0));
    add_row(row(32'h8000_0000, 0, -32'd65536, 32'h1000_0000, 32'h7fff_ffff,
                0, 0, 0, 0));
    add_row(row(0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, -32'd1,
                0, 0, 0, 0));
    add_row(row(32'h8000_0000, 32'h8000_0000, -32'd3, 32'h0001_0000,
                -32'd7, 0, 0, 0, 0));
    foreach (directed[i]) send_with_gap(directed[i].p, directed[i].known, directed[i].v, 0);
    s_axis_tvalid <= 1'b0;
    wait_idle();

    // friction above one and zero friction, extreme heights
    heights = '{32'h8000_0000, 32'h7fff_ffff, 0, 32'hfffe_0000, HEIGHT_RST};
    mus = '{17'd0, 17'h1ffff, 17'd65536, 17'd65537, 17'd26214};
    for (int ph = 0; ph < 5; ph++) begin
      apb_write(REG_HEIGHT, heights[ph]);
      apb_write(REG_MU, {15'd0, mus[ph]});
      if (ph == 1) hold_off = 1'b1;
      for (int k = 0; k < NUM_RANDOM / 5; k++)
        send_with_gap(rand_particle(), 0, '0, k > 60);
      s_axis_tvalid <= 1'b0;
      wait_idle();
      if (ph < 4) begin
        heights[ph + 1] = (ph == 2) ? $urandom : heights[ph + 1];
        mus[ph + 1] = (ph == 2) ? 17'($urandom) : mus[ph + 1];
      end
    end
    stim_done = 1'b1;
  end

  // receiver: random stalls, one long hold-off to back the pipeline up
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    velocity_t got;
    velocity_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_vel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_vel_q.pop_front();
        if (got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
            got.vel_z !== want.vel_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h z=%h got x=%h y=%h z=%h",
                     want.vel_x, want.vel_y, want.vel_z,
                     got.vel_x, got.vel_y, got.vel_z);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_ni);
    while (!stim_done && idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    if (idle_cycles >= WATCHDOG_LIMIT || expected_vel_q.size() != 0) begin
      $display("*** FAILED ***");
    end else if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
hdl/pcf_pkg.sv
hdl/pcf_isqrt.sv
hdl/pcf_div2.sv
hdl/pcf_contact.sv
hdl/particle_plane_friction_collision.sv
hdl/pcf_checker.sv
tb/tb_particle_plane_friction_collision.sv
